[rtl/ssi_pkg.sv]
// ssi_pkg: shared constants and types for the sorted set insert block.
// Used by the channel interfaces, the generic RAM instance and the top level.
// No dependencies.
package ssi_pkg;

   localparam int CAPACITY = 16;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef logic [CNT_W-1:0] cnt_type;

   // low bits of a count-wide value, zero extended first for small capacities
   function automatic logic [POS_W-1:0] to_pos(cnt_type v);
      logic [CNT_W+COUNT_W-1:0] ext;
      ext = {{COUNT_W{1'b0}}, v};
      return ext[POS_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] to_count(cnt_type v);
      logic [CNT_W+COUNT_W-1:0] ext;
      ext = {{COUNT_W{1'b0}}, v};
      return ext[COUNT_W-1:0];
   endfunction

endpackage

[rtl/ssi_req_if.sv]
// ssi_req_if: request channel carrying one value to insert.
// Depends on ssi_pkg.
interface ssi_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ssi_pkg::VALUE_W-1:0]  new_value;

   modport source (output valid, output new_value, input ready);
   modport sink   (input valid, input new_value, output ready);
endinterface

[rtl/ssi_rsp_if.sv]
// ssi_rsp_if: response channel carrying status, position and entry count.
// Depends on ssi_pkg.
interface ssi_rsp_if;
   logic                            valid;
   logic                            ready;
   ssi_pkg::status_type             status;
   logic [ssi_pkg::POS_W-1:0]       insert_position;
   logic [ssi_pkg::COUNT_W-1:0]     entry_count;

   modport source (output valid, output status, output insert_position,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input insert_position,
                   input entry_count, output ready);
endinterface

[rtl/sorted_set_insert_top.sv]
// sorted_set_insert_top: bounded ascending set of signed values with insert.
// Depends on ssi_pkg, ssi_req_if, ssi_rsp_if and ssi_ram.
//
//   channel   dir   handshake          payload
//   req_bus   in    valid / ready      new_value
//   rsp_bus   out   valid / ready      status, insert_position, entry_count
//
// one transaction at a time: ready only while idle. a walk through the entry
// RAM (one read per cycle) finds the slot, a second walk moves larger entries
// up one slot (read and write each cycle), then the value is written.
// an insert at slot p with n entries shifts the n - p entries above it; rejects
// skip the shift and the write, with p the slot where the walk stops.
// reset clears the state, the count and the response valid only.
// a stalled response holds in its register; the next request is taken once
// the result is loaded there.
module sorted_set_insert_top (
   input  logic          clock,
   input  logic          reset,
   ssi_req_if.sink       req_bus,
   ssi_rsp_if.source     rsp_bus
);

   localparam int AW = ssi_pkg::ADDR_W;
   localparam int CW = ssi_pkg::CNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_PLACE,
      S_REPLY
   } state_type;

   state_type                           state_ff, state_in;
   ssi_pkg::cnt_type                    count_ff, count_in;
   ssi_pkg::cnt_type                    idx_ff, idx_in;
   ssi_pkg::cnt_type                    pos_ff, pos_in;
   logic signed [ssi_pkg::VALUE_W-1:0]  value_ff, value_in;
   ssi_pkg::status_type                 status_ff, status_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   ssi_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic [ssi_pkg::POS_W-1:0]           rsp_pos_ff, rsp_pos_in;
   logic [ssi_pkg::COUNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic                                wr_en;
   logic [AW-1:0]                       wr_addr;
   logic [ssi_pkg::VALUE_W-1:0]         wr_data;
   logic [AW-1:0]                       rd_addr;
   logic [ssi_pkg::VALUE_W-1:0]         rd_data;

   ssi_pkg::cnt_type                    idx_inc;
   ssi_pkg::cnt_type                    idx_dec;
   ssi_pkg::cnt_type                    idx_dec2;
   ssi_pkg::cnt_type                    count_dec;
   logic                                at_end;
   logic                                below;
   logic                                hit;

   ssi_ram #(
      .WIDTH (ssi_pkg::VALUE_W),
      .DEPTH (ssi_pkg::CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign idx_inc   = idx_ff + CW'(1);
   assign idx_dec   = idx_ff - CW'(1);
   assign idx_dec2  = idx_ff - CW'(2);
   assign count_dec = count_ff - CW'(1);
   assign at_end    = (idx_ff == count_ff);
   assign below     = $signed(rd_data) < value_ff;
   assign hit       = !at_end && ($signed(rd_data) == value_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = rd_data;
      rd_addr       = '0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // slot 0 is read on accept so the walk starts with data in hand
            rd_addr = '0;
            if (req_bus.valid) begin
               value_in = req_bus.new_value;
               idx_in   = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            rd_addr = idx_inc[AW-1:0];
            if (at_end || !below) begin
               pos_in = idx_ff;
               if (hit) begin
                  status_in = ssi_pkg::ST_DUPLICATE;
                  state_in  = S_REPLY;
               end else if (count_ff == CW'(ssi_pkg::CAPACITY)) begin
                  status_in = ssi_pkg::ST_FULL;
                  pos_in    = '0;
                  state_in  = S_REPLY;
               end else if (at_end) begin
                  status_in = ssi_pkg::ST_INSERTED;
                  state_in  = S_PLACE;
               end else begin
                  // move entries from the top down, starting at the last one
                  status_in = ssi_pkg::ST_INSERTED;
                  rd_addr   = count_dec[AW-1:0];
                  idx_in    = count_ff;
                  state_in  = S_SHIFT;
               end
            end else begin
               idx_in = idx_inc;
            end
         end
         S_SHIFT: begin
            // rd_data holds entry idx-1, written one slot up
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            rd_addr = idx_dec2[AW-1:0];
            idx_in  = idx_dec;
            if (idx_dec == pos_ff) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[AW-1:0];
            wr_data  = value_ff;
            count_in = count_ff + CW'(1);
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pos_in    = ssi_pkg::to_pos(pos_ff);
               rsp_count_in  = ssi_pkg::to_count(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_bus.ready           = (state_ff == S_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.insert_position = rsp_pos_ff;
   assign rsp_bus.entry_count     = rsp_count_ff;

endmodule

[rtl/ssi_ram.sv]
// ssi_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module ssi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[dv/ssi_insert_checker.sv]
`timescale 1ns / 1ps
// ssi_insert_checker: watches the request and response channels of the sorted set
// insert block, keeps its own copy of the set and checks every response in order.
// Depends on ssi_pkg, ssi_req_if and ssi_rsp_if.
module ssi_insert_checker (
   input  logic   clock,
   input  logic   reset,
   ssi_req_if     req_mon,
   ssi_rsp_if     rsp_mon,
   output int     fail_count,
   output int     outstanding
);

   typedef struct packed {
      ssi_pkg::status_type              status;
      logic [ssi_pkg::POS_W-1:0]        position;
      logic [ssi_pkg::COUNT_W-1:0]      count;
   } insert_outcome_type;

   logic signed [ssi_pkg::VALUE_W-1:0] set_entries [ssi_pkg::CAPACITY];
   int                                 set_size;
   insert_outcome_type                 insert_outcome_q [$];
   insert_outcome_type                 exp_outcome;

   // walks the stored set, then updates it exactly as one insert would
   function automatic insert_outcome_type apply_insert(
      logic signed [ssi_pkg::VALUE_W-1:0] value);
      insert_outcome_type outcome;
      int                 slot;
      slot = 0;
      while (slot < set_size && set_entries[slot] < value)
         slot++;
      if (slot < set_size && set_entries[slot] == value) begin
         outcome.status   = ssi_pkg::ST_DUPLICATE;
         outcome.position = ssi_pkg::POS_W'(slot);
      end else if (set_size >= ssi_pkg::CAPACITY) begin
         outcome.status   = ssi_pkg::ST_FULL;
         outcome.position = '0;
      end else begin
         for (int i = set_size; i > slot; i--)
            set_entries[i] = set_entries[i - 1];
         set_entries[slot] = value;
         set_size++;
         outcome.status   = ssi_pkg::ST_INSERTED;
         outcome.position = ssi_pkg::POS_W'(slot);
      end
      outcome.count = ssi_pkg::COUNT_W'(set_size);
      return outcome;
   endfunction

   assign outstanding = insert_outcome_q.size();

   always @(posedge clock) begin
      if (reset) begin
         insert_outcome_q.delete();
         set_size   = 0;
         fail_count = 0;
      end else begin
         // the response of an older transaction is retired before a new one is queued
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (insert_outcome_q.size() == 0) begin
               $display("%0t: unexpected response, actual status %0d position %0d count %0d",
                        $time, rsp_mon.status, rsp_mon.insert_position,
                        rsp_mon.entry_count);
               fail_count++;
            end else begin
               exp_outcome = insert_outcome_q.pop_front();
               if (rsp_mon.status !== exp_outcome.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, exp_outcome.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.insert_position !== exp_outcome.position) begin
                  $display("%0t: insert_position mismatch, expected %0d, actual %0d",
                           $time, exp_outcome.position, rsp_mon.insert_position);
                  fail_count++;
               end
               if (rsp_mon.entry_count !== exp_outcome.count) begin
                  $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                           $time, exp_outcome.count, rsp_mon.entry_count);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            insert_outcome_q.push_back(apply_insert(req_mon.new_value));
      end
   end

endmodule

[dv/tb_sorted_set_insert_top.sv]
`timescale 1ns / 1ps
// tb_sorted_set_insert_top: stimulus and verdict for sorted_set_insert_top.
// Depends on ssi_pkg, ssi_req_if, ssi_rsp_if, the block and ssi_insert_checker.
module tb_sorted_set_insert_top;

   localparam int RANDOM_ITEMS = 550;
   localparam int HOLD_OFF     = 300;

   localparam logic signed [ssi_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [ssi_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   // fills the set through every kind of insert, then hits it while full
   localparam logic signed [ssi_pkg::VALUE_W-1:0] DIRECTED_VALUES [24] = '{
      32'sd0, 32'sd0, VAL_MIN, VAL_MAX, -32'sd1, 32'sd1, VAL_MIN, VAL_MAX,
      32'sd1000, -32'sd1000, 32'sd500, -32'sd500, 32'sh4000_0000, 32'shc000_0000,
      32'sd2, -32'sd2, 32'sd7, VAL_MAX - 1, VAL_MIN + 1,
      32'sd3, VAL_MIN, VAL_MAX, 32'sd500, -32'sd3
   };

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   items_sent = 0;
   int   cycle_count = 0;
   bit   pressure_done = 1'b0;

   ssi_req_if req_bus ();
   ssi_rsp_if rsp_bus ();

   sorted_set_insert_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   ssi_insert_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count++;

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [ssi_pkg::VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return DIRECTED_VALUES[$urandom_range(0, 23)];
      else if (roll < 50)
         return VAL_MIN + $urandom_range(0, 3);
      else if (roll < 60)
         return VAL_MAX - $urandom_range(0, 3);
      else if (roll < 70)
         return $signed(32'($urandom_range(0, 16))) - 32'sd8;
      else
         return $urandom();
   endfunction

   // entered and left at a falling edge
   task automatic send_value(input logic signed [ssi_pkg::VALUE_W-1:0] value);
      int gap;
      gap = ((items_sent / 64) % 4 == 3) ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.new_value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // response side: random stalls, quiet stretches and one long hold-off
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (!pressure_done && items_sent >= 120) begin
            pressure_done = 1'b1;
            hold = HOLD_OFF - 1;
            rsp_bus.ready <= 1'b0;
         end else if ((cycle_count / 512) % 4 == 1) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            hold = pick_gap();
            rsp_bus.ready <= (hold == 0);
            if (hold > 0) hold--;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.new_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_VALUES[i])
         send_value(DIRECTED_VALUES[i]);
      repeat (RANDOM_ITEMS) send_value(pick_value());
      req_bus.valid <= 1'b0;
      wait (outstanding == 0);
      repeat (2 * ssi_pkg::CAPACITY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout with %0d responses outstanding", outstanding);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[sim.f]
rtl/ssi_pkg.sv
rtl/ssi_req_if.sv
rtl/ssi_rsp_if.sv
rtl/ssi_ram.sv
rtl/sorted_set_insert_top.sv
dv/ssi_insert_checker.sv
dv/tb_sorted_set_insert_top.sv
